/* design/udiv_pkg.sv */
// ----------------------------------------------------------------------------
// udiv_pkg
// Shared types and constants for the pipelined unsigned divider.
// ----------------------------------------------------------------------------
`default_nettype none

package udiv_pkg;

    // Width of each operand and result field on the ports.
    localparam int FIELD_WIDTH = 64;
    // Width of the arithmetic.
    // Operand bits above it are ignored, and result bits above it are zero.
    localparam int DATA_WIDTH  = 64;

    // Input request: dividend and divisor.
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] dividend;
        logic [FIELD_WIDTH-1:0] divisor;
    } t_in;

    // Output request: quotient and remainder.
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] quotient;
        logic [FIELD_WIDTH-1:0] remainder;
    } t_out;

    // Working state that travels down the pipeline.
    // nq holds the dividend bits that are still unused in its upper part and
    // the quotient bits found so far in its lower part.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] nq;
        logic [DATA_WIDTH-1:0] dsr;
    } t_stage;

endpackage

`default_nettype wire

/* design/udiv_step.sv */
// ----------------------------------------------------------------------------
// udiv_step
// One restoring shift-and-subtract step followed by a stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module udiv_step (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire udiv_pkg::t_stage i_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output udiv_pkg::t_stage    o_data
);
    import udiv_pkg::*;

    logic                  r_valid;
    t_stage                r_data;
    t_stage                n_data;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    // The top bit of the shifted remainder acts as the carry out of the
    // shift, so large divisors are still handled exactly.
    always_comb begin
        shifted    = {i_data.rem, i_data.nq[DATA_WIDTH-1]};
        diff       = shifted - {1'b0, i_data.dsr};
        fits       = ~diff[DATA_WIDTH];
        n_data.rem = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        n_data.nq  = {i_data.nq[DATA_WIDTH-2:0], fits};
        n_data.dsr = i_data.dsr;
    end

    // The stage takes a new request when it is empty or its content moves on.
    assign o_ready = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

/* design/unsigned_divider_64bit.sv */
// ----------------------------------------------------------------------------
// unsigned_divider_64bit
// Pipelined unsigned restoring divider giving quotient and remainder.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake                   Payload
//   in       input      i_in_valid / o_in_ready     i_in  (dividend, divisor)
//   out      output     o_out_valid / i_out_ready   o_out (quotient, remainder)
//
// One restoring step per stage, DATA_WIDTH stages (64), and one request can
// enter every cycle while the output is not stalled. The last stage register
// is the output register.
// Reset clears the valid bit of every stage; data registers are not reset.
// A stall lets empty stages ahead of the output keep filling, so gaps in the
// pipeline close up while the output waits.
// A zero divisor gives an all-ones quotient and the dividend as remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_divider_64bit (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  wire udiv_pkg::t_in i_in,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output udiv_pkg::t_out  o_out
);
    import udiv_pkg::*;

    logic   s_valid [0:DATA_WIDTH];
    logic   s_ready [0:DATA_WIDTH];
    t_stage s_data  [0:DATA_WIDTH];

    always_comb begin
        s_data[0].rem = '0;
        s_data[0].nq  = i_in.dividend[DATA_WIDTH-1:0];
        s_data[0].dsr = i_in.divisor[DATA_WIDTH-1:0];
    end

    assign s_valid[0] = i_in_valid;
    assign o_in_ready = s_ready[0];

    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
        udiv_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_data  (s_data[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_data  (s_data[k+1])
        );
    end

    assign s_ready[DATA_WIDTH] = i_out_ready;
    assign o_out_valid         = s_valid[DATA_WIDTH];
    assign o_out.quotient      = FIELD_WIDTH'(s_data[DATA_WIDTH].nq);
    assign o_out.remainder     = FIELD_WIDTH'(s_data[DATA_WIDTH].rem);

endmodule

`default_nettype wire

/* design/udiv_checker.sv */
// ----------------------------------------------------------------------------
// udiv_checker
// Port-level checks on the divider's output channel and its backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module udiv_checker (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_ready,
    input  wire             i_out_valid,
    input  wire             i_out_ready,
    input  wire udiv_pkg::t_out i_out
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output request dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out))
        else $error("output request changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // With the output free to move, every stage can move, so the input is ready.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while output is not blocked");

endmodule

bind unsigned_divider_64bit udiv_checker u_udiv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);

`default_nettype wire
